[rtl/tcp_pseudo_header_checksum_unit_assert.svh]
// Assertion macros for the TCP pseudo-header checksum unit.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef TCP_PSEUDO_HEADER_CHECKSUM_UNIT_ASSERT_SVH
`define TCP_PSEUDO_HEADER_CHECKSUM_UNIT_ASSERT_SVH

// same-cycle implication
`define TPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tcppc_pkg.sv]
// Shared constants and types for the TCP pseudo-header checksum unit.
// No dependencies.
package tcppc_pkg;

  localparam int IP_HEADER_BYTES = 20;
  localparam int COUNT_BITS      = 16;
  localparam int TOT_W           = COUNT_BITS + 1;
  localparam int ACC_W           = 32;
  localparam int LEN_W           = 17;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] ADDR_FIRST = COUNT_BITS'(12);
  localparam logic [COUNT_BITS-1:0] CSUM_IDX   = COUNT_BITS'(IP_HEADER_BYTES + 16);
  localparam logic [TOT_W-1:0]      MIN_PKT    = TOT_W'(IP_HEADER_BYTES + 20);
  localparam logic [15:0]           PROTO_TCP  = 16'd6;

  // end-of-packet terms handed to the finishing stage
  typedef struct packed {
    logic [ACC_W-1:0] acc;        // word sum including the last beat
    logic [LEN_W-1:0] len_proto;  // segment length plus protocol
    logic             too_short;
  } final_t;

endpackage

[rtl/tcppc_accum.sv]
// Per-packet byte counter, word assembly and running sum.
// Depends on tcppc_pkg.
module tcppc_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output tcppc_pkg::final_t fin
);
  import tcppc_pkg::*;

  logic [COUNT_BITS-1:0] byte_count;
  logic [ACC_W-1:0]      accumulator;
  logic [7:0]            held_high_byte;

  logic                  live;
  logic                  counts;
  logic [7:0]            v;
  logic [15:0]           word;
  logic [ACC_W-1:0]      acc_add;
  logic [TOT_W-1:0]      total;
  logic [15:0]           seg_len;

  always_comb begin
    live   = byte_count != COUNT_MAX;
    // header bytes before the addresses and the checksum field count as zero
    counts = (byte_count >= ADDR_FIRST) && (byte_count != CSUM_IDX) &&
             (byte_count != CSUM_IDX + COUNT_BITS'(1));
    v      = counts ? data_byte : 8'h00;
    if (!live) begin
      word = 16'h0000;
    end else if (byte_count[0]) begin
      word = {held_high_byte, v};
    end else begin
      word = last_byte ? {v, 8'h00} : 16'h0000;   // odd tail, zero pad
    end
    acc_add = accumulator + ACC_W'(word);
    total   = live ? (TOT_W'(byte_count) + TOT_W'(1)) : {1'b1, {COUNT_BITS{1'b0}}};
    seg_len = 16'(32'(total) - 32'(IP_HEADER_BYTES));
    fin.acc       = acc_add;
    fin.len_proto = LEN_W'(seg_len) + LEN_W'(PROTO_TCP);
    fin.too_short = total < MIN_PKT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      accumulator    <= '0;
      held_high_byte <= '0;
    end else if (step) begin
      if (last_byte) begin
        byte_count     <= '0;
        accumulator    <= '0;
        held_high_byte <= '0;
      end else begin
        accumulator <= acc_add;
        if (live) begin
          byte_count <= byte_count + COUNT_BITS'(1);
          if (!byte_count[0]) begin
            held_high_byte <= v;
          end
        end
      end
    end
  end

endmodule

[rtl/tcp_pseudo_header_checksum_unit.sv]
// TCP checksum over an IPv4 packet (20-byte header) with pseudo-header.
// Throughput: one byte beat per cycle unless in_stall holds a last beat;
// input register, sum stage and output register each advance independently,
// so non-last bytes keep flowing while a result waits. Reset (rst, sync)
// clears all valid flags and the sum state.
// Depends on tcppc_pkg, tcppc_accum and the assertion macro header.
module tcp_pseudo_header_checksum_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tcp_sum,
  output logic        too_short
);
  import tcppc_pkg::*;

  `include "tcp_pseudo_header_checksum_unit_assert.svh"

  // input register
  logic       v1;
  logic [7:0] data1;
  logic       last1;

  // end-of-packet stage
  logic       v2;
  final_t     fin;
  final_t     fin2;

  // stage moves
  logic       out_load;   // output register can take a result
  logic       s2_free;
  logic       s1_move;

  // finishing fold
  logic [17:0] r1;
  logic [16:0] r2;
  logic [15:0] r3;

  assign out_load = !out_valid || !out_stall;
  assign s2_free  = !v2 || out_load;
  // non-last bytes only touch the running sum, never wait on the output
  assign s1_move  = v1 && (!last1 || s2_free);
  assign in_stall = v1 && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data1 <= data_byte;
      last1 <= last_byte;
    end
  end

  tcppc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_move),
    .data_byte (data1),
    .last_byte (last1),
    .fin       (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= s1_move && last1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_move && last1) begin
      fin2 <= fin;
    end
  end

  // end-around carry fold of sum halves plus length and protocol
  always_comb begin
    r1 = 18'(fin2.acc[31:16]) + 18'(fin2.acc[15:0]) + 18'(fin2.len_proto);
    r2 = 17'(r1[15:0]) + 17'(r1[17:16]);
    r3 = r2[15:0] + 16'(r2[16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && v2) begin
      too_short <= fin2.too_short;
      tcp_sum   <= fin2.too_short ? 16'h0000 : ~r3;
    end
  end

  // short packets carry a zero sum
  `TPC_ASSERT_NOW(a_short_zero, out_valid && too_short, tcp_sum == 16'h0000,
    "short packet result has nonzero sum")
  // a last beat always lands in the end-of-packet stage
  `TPC_ASSERT_NEXT(a_last_lands, s1_move && last1, v2,
    "last beat lost on its way to the end-of-packet stage")
  // a waiting end-of-packet result is never overwritten
  `TPC_ASSERT_NOW(a_no_overwrite, v2 && !out_load, !(s1_move && last1),
    "end-of-packet stage overwritten while blocked")

endmodule

[tb/tcp_pseudo_header_checksum_unit_checker.sv]
`timescale 1ns / 100ps
// Checker for the TCP pseudo-header checksum unit: watches both channels,
// predicts the checksum of each packet and compares it with the result beats.
// Depends on tcppc_pkg for the header size, counter width and field offsets.
module tcp_pseudo_header_checksum_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] tcp_sum,
  input  logic        too_short,
  output int          fail_count,
  output int          pending
);
  import tcppc_pkg::*;

  typedef struct packed {
    logic [15:0] sum;
    logic        too_short;
  } csum_result_t;

  csum_result_t csum_due[$];

  // running state of the packet now arriving
  logic [COUNT_BITS-1:0] byte_idx;
  logic [31:0]           word_acc;
  logic [7:0]            hi_byte;

  // one's-complement add, folded as soon as bit 31 shows up
  function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] w);
    logic [31:0] s;
    s = acc + {16'd0, w};
    if (s[31])
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s;
  endfunction

  // bytes 0..11 of the IP header and the TCP checksum field stay out of the sum
  function automatic logic byte_in_sum(input logic [COUNT_BITS-1:0] idx);
    return !(idx < ADDR_FIRST || idx == CSUM_IDX || idx == CSUM_IDX + COUNT_BITS'(1));
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    logic [COUNT_BITS-1:0] idx;
    logic                  live;
    logic [7:0]            v;
    logic [TOT_W-1:0]      total;
    logic [31:0]           acc;
    logic [15:0]           seg_len;
    csum_result_t          res;
    idx  = byte_idx;
    live = (idx != COUNT_MAX);
    if (live) begin
      v = byte_in_sum(idx) ? b : 8'd0;
      if (!idx[0]) begin
        hi_byte = v;
        if (is_last)
          word_acc = ones_add(word_acc, {v, 8'd0});
      end else begin
        word_acc = ones_add(word_acc, {hi_byte, v});
      end
      byte_idx = idx + COUNT_BITS'(1);
    end
    if (is_last) begin
      // saturated counter: length is taken as one past the top index
      total   = live ? TOT_W'(idx) + TOT_W'(1) : TOT_W'(COUNT_MAX) + TOT_W'(1);
      seg_len = 16'(total - TOT_W'(IP_HEADER_BYTES));
      acc     = ones_add(word_acc, PROTO_TCP);
      acc     = ones_add(acc, seg_len);
      while (acc[31:16] != 16'd0)
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      res.too_short = (total < MIN_PKT);
      res.sum       = res.too_short ? 16'd0 : ~acc[15:0];
      csum_due.push_back(res);
      byte_idx = '0;
      word_acc = '0;
      hi_byte  = '0;
    end
  endtask

  always @(posedge clk) begin
    csum_result_t got_due;
    if (rst) begin
      byte_idx = '0;
      word_acc = '0;
      hi_byte  = '0;
      csum_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (csum_due.size() == 0) begin
          $display("%0t: result beat with none expected: tcp_sum %h too_short %b",
                   $time, tcp_sum, too_short);
          fail_count++;
        end else begin
          got_due = csum_due.pop_front();
          if (tcp_sum !== got_due.sum) begin
            $display("%0t: tcp_sum expected %h got %h", $time, got_due.sum, tcp_sum);
            fail_count++;
          end
          if (too_short !== got_due.too_short) begin
            $display("%0t: too_short expected %b got %b", $time, got_due.too_short,
                     too_short);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        absorb_byte(data_byte, last_byte);
    end
    pending <= csum_due.size();
  end

endmodule

[tb/tcp_pseudo_header_checksum_unit_tb.sv]
`timescale 1ns / 100ps
// Top of the TCP pseudo-header checksum unit testbench: clock, reset, packet
// stimulus, receiver stalls and the verdict. Needs the unit and the checker.
module tcp_pseudo_header_checksum_unit_tb;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] tcp_sum;
  logic        too_short;

  int fail_count;
  int pending;

  // idle odds in percent per cycle; sender side is used only by this process
  int idle_pct  = 0;
  int stall_pct = 0;

  // one-shot long receiver hold-off, counted in the receiver process
  int hold_cycles = 0;
  int held_cnt    = 0;

  // per-phase idle settings of the random part
  int idle_tab[4]  = '{0, 87, 0, 31};
  int stall_tab[4] = '{0, 0, 87, 31};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tcp_pseudo_header_checksum_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tcp_sum   (tcp_sum),
    .too_short (too_short)
  );

  tcp_pseudo_header_checksum_unit_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tcp_sum    (tcp_sum),
    .too_short  (too_short),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: the long hold-off wins over the random stall odds.
  always @(posedge clk) begin
    if (held_cnt < hold_cycles) begin
      out_stall <= 1'b1;
      held_cnt  <= held_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one beat, idling first at random; returns just after the edge
  // that took it. The payload holds steady while in_stall is high.
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic send_packet(input int len, input fill_e fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES: b = 8'hff;
        FILL_ZERO: b = 8'h00;
        default:   b = 8'($urandom);
      endcase
      send_beat(b, i == len - 1);
    end
  endtask

  // Drop valid and wait until every predicted checksum has come out.
  // The extra edge lets the checker's pending count catch the last push.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  initial begin
    int    len;
    int    pick;
    int    phase_bytes;
    int    phase_pkts;
    fill_e fill;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed packets, no idling.
    send_packet(1, FILL_ONES);      // lone byte, last on an even index
    send_packet(2, FILL_RANDOM);    // last on an odd index
    send_packet(39, FILL_ONES);     // one byte short of a TCP header
    send_packet(40, FILL_ONES);     // shortest full packet, checksum field ignored
    send_packet(40, FILL_ZERO);
    send_packet(41, FILL_RANDOM);   // odd tail padded with a zero low byte
    send_packet(64, FILL_RANDOM);
    send_packet(60, FILL_ONES);     // all-ones segment past the minimum
    drain();

    // Long output hold-off while tiny packets keep coming, so the result
    // path backs up into in_stall. Then pause until it all drains.
    hold_cycles <= 400;
    do begin
      send_packet($urandom_range(1, 3), FILL_RANDOM);
    end while (held_cnt < hold_cycles);
    drain();

    // Random packets: mostly well-formed lengths, some short ones as noise.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = idle_tab[ph];
      stall_pct  <= stall_tab[ph];
      phase_bytes = 0;
      phase_pkts  = 0;
      while (phase_bytes < 100 || phase_pkts < 2) begin
        pick = $urandom_range(0, 99);
        if (pick < 25)
          len = $urandom_range(1, 39);
        else if (pick < 90)
          len = $urandom_range(40, 64);
        else
          len = $urandom_range(65, 160);
        pick = $urandom_range(0, 99);
        if (pick < 10)
          fill = FILL_ONES;
        else if (pick < 15)
          fill = FILL_ZERO;
        else
          fill = FILL_RANDOM;
        send_packet(len, fill);
        phase_bytes += len;
        phase_pkts++;
      end
    end

    drain();
    repeat (12) @(posedge clk);   // leave room for strays
    if (fail_count == 0)
      $display("tcp_pseudo_header_checksum_unit_tb: PASS");
    else
      $display("tcp_pseudo_header_checksum_unit_tb: FAIL");
    $finish;
  end

  // watchdog: far above the slowest expected run
  initial begin
    #8000000;
    $display("tcp_pseudo_header_checksum_unit_tb: FAIL");
    $finish;
  end

endmodule
